FILE: sv/etl_pkg.sv
// ----------------------------------------------------------------------------
// Expression token lexer package
// Payload types, token kind codes and character codes shared by the lexer.
// ----------------------------------------------------------------------------
package etl_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_end;
      logic        last_of_run;
   } rsp_type;

   // Token kinds.
   localparam logic [3:0] TK_PLUS   = 4'd0;
   localparam logic [3:0] TK_MINUS  = 4'd1;
   localparam logic [3:0] TK_MUL    = 4'd2;
   localparam logic [3:0] TK_DIV    = 4'd3;
   localparam logic [3:0] TK_ASSIGN = 4'd4;
   localparam logic [3:0] TK_MOD    = 4'd5;
   localparam logic [3:0] TK_FACT   = 4'd6;
   localparam logic [3:0] TK_LPAREN = 4'd7;
   localparam logic [3:0] TK_RPAREN = 4'd8;
   localparam logic [3:0] TK_POW    = 4'd9;
   localparam logic [3:0] TK_INT    = 4'd10;
   localparam logic [3:0] TK_FLT    = 4'd11;
   localparam logic [3:0] TK_IDENT  = 4'd12;
   localparam logic [3:0] TK_EOL    = 4'd13;
   localparam logic [3:0] TK_ERR    = 4'd14;

   // Input item kinds.
   localparam logic ITEM_CHAR = 1'b0;
   localparam logic ITEM_EOS  = 1'b1;

   // Character codes.
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_LE     = 8'h65;
   localparam logic [7:0] CH_UE     = 8'h45;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
   endfunction

   // Returns {is_operator, kind} for the single-character operators.
   function automatic logic [4:0] op_code(input logic [7:0] c);
      logic [4:0] r;
      case (c)
         CH_PLUS:   r = {1'b1, TK_PLUS};
         CH_MINUS:  r = {1'b1, TK_MINUS};
         CH_STAR:   r = {1'b1, TK_MUL};
         CH_SLASH:  r = {1'b1, TK_DIV};
         CH_EQUAL:  r = {1'b1, TK_ASSIGN};
         CH_PCT:    r = {1'b1, TK_MOD};
         CH_BANG:   r = {1'b1, TK_FACT};
         CH_LPAREN: r = {1'b1, TK_LPAREN};
         CH_RPAREN: r = {1'b1, TK_RPAREN};
         CH_CARET:  r = {1'b1, TK_POW};
         default:   r = {1'b0, TK_ERR};
      endcase
      return r;
   endfunction

endpackage

FILE: sv/expression_token_lexer_top.sv
// ----------------------------------------------------------------------------
// Expression token lexer
// Groups a stream of characters into arithmetic expression tokens.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one character per transfer, or an end-of-string
// item that closes the expression. The rsp channel carries tokens with a
// kind, a start position and an end position (one past the last character);
// last_of_run marks the final token caused by one request transfer.
// The lexer state and the character position are updated in the cycle of
// the request transfer, and the tokens it causes land in a three-entry
// output queue, and are offered from its registers once earlier tokens leave.
// A request yields zero, one or two tokens; one token leaves per cycle
// while rsp_stall is low. Two come from a delimiter that ends a number
// or identifier and is itself an operator or an error, or from an end of
// string that closes an open token before the end of line.
// req_stall rises only while two or more tokens are queued, which is what
// bounds the rate at the output port.
// After an error the lexer drops characters until end of string.
// Reset (synchronous) empties the queue and returns the lexer to the
// new-token state at position zero. While rsp_stall is high the head token
// holds and the queue fills; requests stall once it cannot take two more.
// ----------------------------------------------------------------------------
module expression_token_lexer_top
   import etl_pkg::*;
#(
   parameter int POS_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Lexer states.
   localparam logic [2:0] ST_NEW   = 3'd0;
   localparam logic [2:0] ST_INT   = 3'd1;
   localparam logic [2:0] ST_IDENT = 3'd2;
   localparam logic [2:0] ST_FRAC  = 3'd3;
   localparam logic [2:0] ST_SEXP  = 3'd4;
   localparam logic [2:0] ST_EXP   = 3'd5;
   localparam logic [2:0] ST_HALT  = 3'd6;

   localparam logic [POS_WIDTH-1:0] POS_ALL   = '1;
   localparam logic [POS_WIDTH-1:0] POS_LIMIT = POS_ALL - 1'b1;

   // Positions leave the block as their low sixteen bits, zero extended
   // when the position counter is narrower.
   function automatic logic [15:0] fit(input logic [POS_WIDTH-1:0] p);
      logic [POS_WIDTH+15:0] w;
      w = {16'd0, p};
      return w[15:0];
   endfunction

   function automatic logic [1:0] next_slot(input logic [1:0] s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [POS_WIDTH-1:0] begin_ff, begin_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;

   rsp_type    queue_ff [3];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   logic                 req_fire, rsp_fire;
   logic [7:0]           c;
   logic [POS_WIDTH-1:0] pos_next;
   logic [4:0]           op;

   // Classification of the character as the start of a new token.
   logic       nc_emit;
   rsp_type    nc_tok;
   logic [2:0] nc_state;
   logic       nc_begin;

   // A token being closed, and a token started, by this transfer.
   logic       close_valid, new_valid;
   rsp_type    close_tok, new_tok;
   logic       use_nc;

   rsp_type    slot0, slot1;
   logic [1:0] push_n;

   assign req_stall = count_ff[1];
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = queue_ff[rd_ff];
   assign rsp_fire  = rsp_valid && !rsp_stall;

   assign c        = req_data.char_code;
   assign pos_next = pos_ff + 1'b1;
   assign op       = op_code(c);

   always_comb begin
      nc_emit  = 1'b0;
      nc_state = ST_NEW;
      nc_begin = 1'b0;
      nc_tok   = '{token_kind: TK_ERR, token_start: fit(pos_ff),
                   token_end: fit(pos_next), last_of_run: 1'b0};
      if (op[4]) begin
         nc_emit           = 1'b1;
         nc_tok.token_kind = op[3:0];
      end else if (c == CH_SPACE) begin
         nc_state = ST_NEW;
      end else if (c == CH_DOT) begin
         nc_state = ST_FRAC;
         nc_begin = 1'b1;
      end else if (is_digit(c)) begin
         nc_state = ST_INT;
         nc_begin = 1'b1;
      end else if (is_alpha(c)) begin
         nc_state = ST_IDENT;
         nc_begin = 1'b1;
      end else begin
         nc_emit  = 1'b1;
         nc_state = ST_HALT;
      end
   end

   always_comb begin
      state_in    = state_ff;
      begin_in    = begin_ff;
      pos_in      = pos_ff;
      close_valid = 1'b0;
      new_valid   = 1'b0;
      use_nc      = 1'b0;
      close_tok   = '{token_kind: TK_ERR, token_start: fit(begin_ff),
                      token_end: fit(pos_ff), last_of_run: 1'b0};
      new_tok     = '{token_kind: TK_EOL, token_start: fit(pos_ff),
                      token_end: fit(pos_ff), last_of_run: 1'b0};

      if (req_fire) begin
         if (state_ff > ST_EXP) begin
            // Halted: characters are dropped, end of string restarts.
            if (req_data.kind == ITEM_EOS) begin
               state_in = ST_NEW;
               begin_in = '0;
               pos_in   = '0;
            end
         end else if (req_data.kind == ITEM_EOS) begin
            // Close the open token at the string length, then end of line,
            // except when an exponent marker was left without a sign or digits.
            new_valid = 1'b1;
            case (state_ff)
               ST_IDENT: begin
                  close_valid          = 1'b1;
                  close_tok.token_kind = TK_IDENT;
               end
               ST_INT: begin
                  close_valid          = 1'b1;
                  close_tok.token_kind = TK_INT;
               end
               ST_FRAC, ST_EXP: begin
                  close_valid          = 1'b1;
                  close_tok.token_kind = TK_FLT;
               end
               ST_SEXP: begin
                  close_valid = 1'b1;
                  new_valid   = 1'b0;
               end
               default: begin
                  close_valid = 1'b0;
               end
            endcase
            state_in = ST_NEW;
            begin_in = '0;
            pos_in   = '0;
         end else if (pos_ff >= POS_LIMIT) begin
            // String too long for the position counter.
            close_valid           = 1'b1;
            close_tok.token_start = fit(POS_ALL);
            close_tok.token_end   = 16'd0;
            state_in              = ST_HALT;
         end else begin
            pos_in = pos_next;
            case (state_ff)
               ST_NEW: begin
                  use_nc = 1'b1;
               end
               ST_INT: begin
                  if (is_digit(c)) begin
                     state_in = ST_INT;
                  end else if ((c == CH_LE) || (c == CH_UE)) begin
                     state_in = ST_SEXP;
                  end else if (c == CH_DOT) begin
                     state_in = ST_FRAC;
                  end else begin
                     close_valid          = 1'b1;
                     close_tok.token_kind = TK_INT;
                     use_nc               = 1'b1;
                  end
               end
               ST_FRAC: begin
                  if (is_digit(c)) begin
                     state_in = ST_FRAC;
                  end else if ((c == CH_LE) || (c == CH_UE)) begin
                     state_in = ST_SEXP;
                  end else begin
                     close_valid          = 1'b1;
                     close_tok.token_kind = TK_FLT;
                     use_nc               = 1'b1;
                  end
               end
               ST_SEXP: begin
                  if ((c == CH_PLUS) || (c == CH_MINUS) || is_digit(c)) begin
                     state_in = ST_EXP;
                  end else begin
                     close_valid         = 1'b1;
                     close_tok.token_end = fit(pos_next);
                     state_in            = ST_HALT;
                  end
               end
               ST_EXP: begin
                  if (!is_digit(c)) begin
                     close_valid          = 1'b1;
                     close_tok.token_kind = TK_FLT;
                     use_nc               = 1'b1;
                  end
               end
               default: begin
                  if (!(is_digit(c) || is_alpha(c) || (c == CH_UNDER))) begin
                     close_valid          = 1'b1;
                     close_tok.token_kind = TK_IDENT;
                     use_nc               = 1'b1;
                  end
               end
            endcase
            if (use_nc) begin
               new_valid = nc_emit;
               new_tok   = nc_tok;
               state_in  = nc_state;
               if (nc_begin) begin
                  begin_in = pos_ff;
               end
            end
         end
      end
   end

   // Pack the closed and started tokens into consecutive queue slots and
   // mark the last one of the run.
   always_comb begin
      slot1 = new_tok;
      if (close_valid) begin
         slot0             = close_tok;
         slot0.last_of_run = !new_valid;
         slot1.last_of_run = 1'b1;
      end else begin
         slot0             = new_tok;
         slot0.last_of_run = 1'b1;
      end
      push_n = {1'b0, close_valid} + {1'b0, new_valid};
   end

   always_comb begin
      rd_in    = rsp_fire ? next_slot(rd_ff) : rd_ff;
      wr_in    = wr_ff;
      if (push_n == 2'd1) begin
         wr_in = next_slot(wr_ff);
      end else if (push_n == 2'd2) begin
         wr_in = next_slot(next_slot(wr_ff));
      end
      count_in = count_ff + push_n - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NEW;
         begin_ff <= '0;
         pos_ff   <= '0;
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         queue_ff[next_slot(wr_ff)] <= slot1;
      end
   end

endmodule
